// ===== rtl/core/mdk_pkg.sv =====
`timescale 1ns / 1ps
package mdk_pkg;

  localparam int AluW      = 64;
  localparam int AluCntW   = 7;
  localparam int MulSteps  = 20;
  localparam int DivSteps  = 64;
  localparam int SqrtSteps = 32;

  typedef enum logic [1:0] {
    ALU_MUL  = 2'd0,
    ALU_DIV  = 2'd1,
    ALU_SQRT = 2'd2
  } alu_op_t;

  typedef struct packed {
    logic            start;
    alu_op_t         op;
    logic [AluW-1:0] a;
    logic [AluW-1:0] b;
  } alu_cmd_t;

  typedef struct packed {
    logic            done;
    logic [AluW-1:0] res;
    logic [AluW-1:0] rem;
  } alu_stat_t;

endpackage

// ===== rtl/core/mdk_alu.sv =====
`timescale 1ns / 1ps
module mdk_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  mdk_pkg::alu_cmd_t cmd,
  output mdk_pkg::alu_stat_t stat
);
  import mdk_pkg::*;

  logic [AluW:0]    y_r;
  logic [AluW-1:0]  x_r;
  logic [AluW-1:0]  z_r;
  alu_op_t          op_r;
  logic [AluCntW-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [AluW:0]    t;
  logic [AluW:0]    trial;
  logic [AluW:0]    dif;

  always_comb begin
    unique case (op_r)
      ALU_DIV: begin
        t     = {y_r[AluW-1:0], x_r[AluW-1]};
        trial = {1'b0, z_r};
      end
      ALU_SQRT: begin
        t     = {y_r[AluW-2:0], x_r[AluW-1:AluW-2]};
        trial = {z_r[AluW-2:0], 2'b01};
      end
      default: begin
        t     = y_r + {1'b0, x_r};
        trial = '0;
      end
    endcase
    dif = t - trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= ALU_MUL;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        op_r   <= cmd.op;
        busy_r <= 1'b1;
        unique case (cmd.op)
          ALU_DIV:  cnt_r <= AluCntW'(DivSteps);
          ALU_SQRT: cnt_r <= AluCntW'(SqrtSteps);
          default:  cnt_r <= AluCntW'(MulSteps);
        endcase
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == AluCntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x_r <= cmd.a;
      z_r <= cmd.b;
      y_r <= '0;
    end else if (busy_r) begin
      unique case (op_r)
        ALU_DIV: begin
          if (t >= trial) begin
            y_r <= dif;
            x_r <= {x_r[AluW-2:0], 1'b1};
          end else begin
            y_r <= t;
            x_r <= {x_r[AluW-2:0], 1'b0};
          end
        end
        ALU_SQRT: begin
          if (t >= trial) begin
            y_r <= dif;
            z_r <= {z_r[AluW-2:0], 1'b1};
          end else begin
            y_r <= t;
            z_r <= {z_r[AluW-2:0], 1'b0};
          end
          x_r <= {x_r[AluW-3:0], 2'b00};
        end
        default: begin
          if (z_r[0]) y_r <= t;
          x_r <= {x_r[AluW-2:0], 1'b0};
          z_r <= {1'b0, z_r[AluW-1:1]};
        end
      endcase
    end
  end

  always_comb begin
    stat.done = done_r;
    stat.rem  = y_r[AluW-1:0];
    unique case (op_r)
      ALU_DIV:  stat.res = x_r;
      ALU_SQRT: stat.res = z_r;
      default:  stat.res = y_r[AluW-1:0];
    endcase
  end

endmodule

// ===== rtl/core/mecanum_drive_kinematics.sv =====
`timescale 1ns / 1ps
// Mecanum chassis kinematics. Each item carries an action in in_tuser: set target
// limits the planar and spin velocity and solves four scaled wheel speeds, tick
// filters the speeds and integrates the pose, load sets the pose and clears the
// speeds. Every item returns one snapshot of the state. All arithmetic runs through
// one shared bit-serial unit, one operation at a time. A tick adds a divide when the
// heading has to be wrapped. A set target adds a square root, multiplies and divides
// when the planar vector is limited, and a multiply and a divide per wheel when the
// wheels are limited. The next item is taken as soon as the last one is handed to
// the output register.
module mecanum_drive_kinematics (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // vel_x, vel_y, spin_speed, step_time, init_x, init_y, init_heading
  input  logic [167:0] in_tdata,
  // action
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // wheel_left_front, wheel_right_front, wheel_left_back, wheel_right_back,
  // filtered_vx, filtered_vy, filtered_rate, pose_x, pose_y, pose_heading, pad
  output logic [247:0] out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [14:0]  cfg_wdata
);
  import mdk_pkg::*;

  typedef enum logic [1:0] {
    ACT_SET  = 2'd0,
    ACT_TICK = 2'd1,
    ACT_LOAD = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    REG_OFFSET    = 3'd0,
    REG_RADIUS    = 3'd1,
    REG_MAX_LIN   = 3'd2,
    REG_MAX_SPIN  = 3'd3,
    REG_MAX_WHEEL = 3'd4,
    REG_ALPHA     = 3'd5
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_ML2, S_SQX, S_SQY, S_SQRT, S_NX, S_DX, S_NY, S_DY, S_NR, S_DR,
    S_NROT, S_DROT, S_WSET, S_WMUL, S_WDIV, S_MIXX, S_MIXY, S_MIXR,
    S_PXM, S_PXD, S_PYM, S_PYD, S_HM, S_HD, S_WRAP, S_DONE
  } state_t;

  localparam logic signed [39:0] HalfTurn  = 40'sd3141590;
  localparam logic signed [23:0] HalfTurnM = 24'sd3141589;
  localparam logic [63:0] FullTurn  = 64'd6283180;
  localparam logic [63:0] Usec      = 64'd1000000;
  localparam logic [63:0] PosDiv    = 64'd256000;
  localparam logic [19:0] UsecMul   = 20'd1000000;

  state_t state_r;
  logic   wait_r;
  logic   out_valid_r;
  logic [247:0] out_data_r;

  logic [11:0] off_r, rad_r;
  logic [13:0] maxl_r, maxs_r;
  logic [14:0] maxw_r;
  logic [8:0]  alpha_r;

  logic signed [14:0] vx_r, vy_r, spin_r;
  logic [19:0] dt_r;

  logic signed [22:0] tvx_r, tvy_r, cvx_r, cvy_r, head_r;
  logic signed [31:0] trate_r, crate_r;
  logic [39:0] posx_r, posy_r;
  logic [15:0] whl_r [4];

  logic [29:0] s_r;
  logic [27:0] lim_r;
  logic [22:0] m8_r;
  logic [63:0] num_r;
  logic signed [40:0] rot_r;
  logic signed [42:0] w_r [4];
  logic [42:0] amax_r;
  logic [1:0]  widx_r;
  logic signed [39:0] h_r;

  alu_cmd_t  alu_cmd;
  alu_stat_t alu_st;

  mdk_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (alu_cmd),
    .stat  (alu_st)
  );

  logic [14:0] vx_mag, vy_mag;
  logic signed [15:0] spin_e, maxs_e, spin_c;
  logic [15:0] spin_mag;
  logic [11:0] rad_eff;
  logic [8:0]  alpha_eff;
  logic [31:0] rate_mag, crate_mag;
  logic [22:0] cvx_mag, cvy_mag;
  logic signed [23:0] dx, dy;
  logic signed [32:0] dr;
  logic [23:0] dx_mag, dy_mag;
  logic [32:0] dr_mag;
  logic        mix_neg;
  logic signed [43:0] mprod;
  logic signed [42:0] wc [4];
  logic [42:0] wc_mag [4];
  logic [42:0] amax_c;
  logic [42:0] wm_sel;
  logic [42:0] wdiv_q;
  logic [29:0] s_sum;
  logic signed [39:0] hdelta, hsum;
  logic        wpos;
  logic [63:0] wnum;
  logic signed [23:0] r24, hwrap;
  logic [39:0] pdelta_x, pdelta_y;
  logic        is_op;
  logic [247:0] pack;

  assign vx_mag   = vx_r[14] ? 15'(-vx_r) : 15'(vx_r);
  assign vy_mag   = vy_r[14] ? 15'(-vy_r) : 15'(vy_r);
  assign spin_e   = 16'(spin_r);
  assign maxs_e   = signed'({2'b00, maxs_r});
  assign spin_c   = (spin_e > maxs_e) ? maxs_e : ((spin_e < -maxs_e) ? -maxs_e : spin_e);
  assign spin_mag = spin_c[15] ? 16'(-spin_c) : 16'(spin_c);
  assign rad_eff  = (rad_r == 12'd0) ? 12'd1 : rad_r;
  assign alpha_eff = (alpha_r > 9'd256) ? 9'd256 : alpha_r;
  assign rate_mag  = trate_r[31] ? 32'(-trate_r) : 32'(trate_r);
  assign crate_mag = crate_r[31] ? 32'(-crate_r) : 32'(crate_r);
  assign cvx_mag   = cvx_r[22] ? 23'(-cvx_r) : 23'(cvx_r);
  assign cvy_mag   = cvy_r[22] ? 23'(-cvy_r) : 23'(cvy_r);
  assign dx = 24'(tvx_r) - 24'(cvx_r);
  assign dy = 24'(tvy_r) - 24'(cvy_r);
  assign dr = 33'(trate_r) - 33'(crate_r);
  assign dx_mag = dx[23] ? 24'(-dx) : 24'(dx);
  assign dy_mag = dy[23] ? 24'(-dy) : 24'(dy);
  assign dr_mag = dr[32] ? 33'(-dr) : 33'(dr);
  assign s_sum  = s_r + alu_st.res[29:0];

  always_comb begin
    unique case (state_r)
      S_MIXX:  mix_neg = dx[23];
      S_MIXY:  mix_neg = dy[23];
      default: mix_neg = dr[32];
    endcase
    mprod = mix_neg ? -signed'({1'b0, alu_st.res[42:0]})
                    :  signed'({1'b0, alu_st.res[42:0]});
  end

  always_comb begin
    wc[0] = 43'(tvx_r) - 43'(tvy_r) - 43'(rot_r);
    wc[1] = -43'(tvx_r) - 43'(tvy_r) + 43'(rot_r);
    wc[2] = -43'(tvx_r) - 43'(tvy_r) - 43'(rot_r);
    wc[3] = 43'(tvx_r) - 43'(tvy_r) + 43'(rot_r);
    amax_c = '0;
    for (int i = 0; i < 4; i++) begin
      wc_mag[i] = wc[i][42] ? 43'(-wc[i]) : 43'(wc[i]);
      if (wc_mag[i] > amax_c) amax_c = wc_mag[i];
    end
    wm_sel = w_r[widx_r][42] ? 43'(-w_r[widx_r]) : 43'(w_r[widx_r]);
    wdiv_q = alu_st.res[42:0];
  end

  assign hdelta = crate_r[31] ? -signed'({7'b0, alu_st.res[32:0]})
                              :  signed'({7'b0, alu_st.res[32:0]});
  assign hsum   = 40'(head_r) + hdelta;
  assign wpos   = (h_r > HalfTurn);
  assign wnum   = wpos ? 64'(h_r - HalfTurn - 40'sd1) : 64'(-HalfTurn - h_r - 40'sd1);
  assign r24    = signed'({1'b0, alu_st.rem[22:0]});
  assign hwrap  = wpos ? (r24 - HalfTurnM) : (HalfTurnM - r24);
  assign pdelta_x = cvx_r[22] ? (40'd0 - alu_st.res[39:0]) : alu_st.res[39:0];
  assign pdelta_y = cvy_r[22] ? (40'd0 - alu_st.res[39:0]) : alu_st.res[39:0];

  always_comb begin
    unique case (state_r)
      S_IDLE, S_WSET, S_DONE: is_op = 1'b0;
      default:                is_op = 1'b1;
    endcase
  end

  always_comb begin
    alu_cmd.start = is_op && !wait_r;
    alu_cmd.op    = ALU_MUL;
    alu_cmd.a     = '0;
    alu_cmd.b     = '0;
    unique case (state_r)
      S_ML2:  begin alu_cmd.a = 64'(maxl_r); alu_cmd.b = 64'(maxl_r); end
      S_SQX:  begin alu_cmd.a = 64'(vx_mag); alu_cmd.b = 64'(vx_mag); end
      S_SQY:  begin alu_cmd.a = 64'(vy_mag); alu_cmd.b = 64'(vy_mag); end
      S_SQRT: begin alu_cmd.op = ALU_SQRT; alu_cmd.a = {18'd0, s_r, 16'd0}; end
      S_NX:   begin alu_cmd.a = {33'd0, vx_mag, 16'd0}; alu_cmd.b = 64'(maxl_r); end
      S_NY:   begin alu_cmd.a = {33'd0, vy_mag, 16'd0}; alu_cmd.b = 64'(maxl_r); end
      S_DX, S_DY: begin
        alu_cmd.op = ALU_DIV; alu_cmd.a = num_r; alu_cmd.b = 64'(m8_r);
      end
      S_NR:   begin alu_cmd.a = 64'(spin_mag); alu_cmd.b = 64'(UsecMul); end
      S_DR:   begin alu_cmd.op = ALU_DIV; alu_cmd.a = num_r; alu_cmd.b = 64'(rad_eff); end
      S_NROT: begin alu_cmd.a = {24'd0, rate_mag, 8'd0}; alu_cmd.b = 64'(off_r); end
      S_DROT: begin alu_cmd.op = ALU_DIV; alu_cmd.a = num_r; alu_cmd.b = Usec; end
      S_WMUL: begin alu_cmd.a = 64'(wm_sel); alu_cmd.b = 64'(maxw_r); end
      S_WDIV: begin alu_cmd.op = ALU_DIV; alu_cmd.a = num_r; alu_cmd.b = 64'(amax_r); end
      S_MIXX: begin alu_cmd.a = 64'(dx_mag); alu_cmd.b = 64'(alpha_eff); end
      S_MIXY: begin alu_cmd.a = 64'(dy_mag); alu_cmd.b = 64'(alpha_eff); end
      S_MIXR: begin alu_cmd.a = 64'(dr_mag); alu_cmd.b = 64'(alpha_eff); end
      S_PXM:  begin alu_cmd.a = 64'(cvx_mag); alu_cmd.b = 64'(dt_r); end
      S_PYM:  begin alu_cmd.a = 64'(cvy_mag); alu_cmd.b = 64'(dt_r); end
      S_HM:   begin alu_cmd.a = 64'(crate_mag); alu_cmd.b = 64'(dt_r); end
      S_PXD, S_PYD: begin alu_cmd.op = ALU_DIV; alu_cmd.a = num_r; alu_cmd.b = PosDiv; end
      S_HD:   begin alu_cmd.op = ALU_DIV; alu_cmd.a = num_r; alu_cmd.b = Usec; end
      S_WRAP: begin alu_cmd.op = ALU_DIV; alu_cmd.a = wnum; alu_cmd.b = FullTurn; end
      default: ;
    endcase
  end

  assign pack = {3'b000, head_r, posy_r, posx_r, crate_r, cvy_r, cvx_r,
                 whl_r[3], whl_r[2], whl_r[1], whl_r[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wait_r      <= 1'b0;
      out_valid_r <= 1'b0;
      off_r   <= 12'd200;
      rad_r   <= 12'd200;
      maxl_r  <= 14'd2000;
      maxs_r  <= 14'd2000;
      maxw_r  <= 15'd3000;
      alpha_r <= 9'd77;
      tvx_r   <= '0;
      tvy_r   <= '0;
      trate_r <= '0;
      cvx_r   <= '0;
      cvy_r   <= '0;
      crate_r <= '0;
      posx_r  <= '0;
      posy_r  <= '0;
      head_r  <= '0;
      for (int i = 0; i < 4; i++) whl_r[i] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_OFFSET:    off_r   <= cfg_wdata[11:0];
          REG_RADIUS:    rad_r   <= cfg_wdata[11:0];
          REG_MAX_LIN:   maxl_r  <= cfg_wdata[13:0];
          REG_MAX_SPIN:  maxs_r  <= cfg_wdata[13:0];
          REG_MAX_WHEEL: maxw_r  <= cfg_wdata[14:0];
          REG_ALPHA:     alpha_r <= cfg_wdata[8:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_tready && state_r != S_DONE) out_valid_r <= 1'b0;

      if (is_op && !wait_r) wait_r <= 1'b1;

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            vx_r   <= in_tdata[14:0];
            vy_r   <= in_tdata[29:15];
            spin_r <= in_tdata[44:30];
            dt_r   <= in_tdata[64:45];
            unique case (in_tuser)
              ACT_SET:  state_r <= S_ML2;
              ACT_TICK: state_r <= S_MIXX;
              ACT_LOAD: begin
                posx_r  <= in_tdata[104:65];
                posy_r  <= in_tdata[144:105];
                head_r  <= in_tdata[167:145];
                tvx_r   <= '0;
                tvy_r   <= '0;
                trate_r <= '0;
                cvx_r   <= '0;
                cvy_r   <= '0;
                crate_r <= '0;
                state_r <= S_DONE;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_WSET: begin
          for (int i = 0; i < 4; i++) begin
            w_r[i] <= wc[i];
            whl_r[i] <= wc[i][42] ? 16'(43'd0 - (wc_mag[i] >> 8)) : 16'(wc_mag[i] >> 8);
          end
          amax_r <= amax_c;
          widx_r <= 2'd0;
          state_r <= (amax_c > 43'({maxw_r, 8'd0})) ? S_WMUL : S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= pack;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          if (wait_r && alu_st.done) begin
            wait_r <= 1'b0;
            num_r  <= alu_st.res;
            unique case (state_r)
              S_ML2: begin
                lim_r   <= alu_st.res[27:0];
                state_r <= S_SQX;
              end
              S_SQX: begin
                s_r     <= alu_st.res[29:0];
                state_r <= S_SQY;
              end
              S_SQY: begin
                s_r <= s_sum;
                if (s_sum > 30'(lim_r)) begin
                  state_r <= S_SQRT;
                end else begin
                  tvx_r   <= {vx_r, 8'd0};
                  tvy_r   <= {vy_r, 8'd0};
                  state_r <= S_NR;
                end
              end
              S_SQRT: begin
                m8_r    <= alu_st.res[22:0];
                state_r <= S_NX;
              end
              S_NX: state_r <= S_DX;
              S_DX: begin
                tvx_r   <= vx_r[14] ? 23'(-alu_st.res[22:0]) : alu_st.res[22:0];
                state_r <= S_NY;
              end
              S_NY: state_r <= S_DY;
              S_DY: begin
                tvy_r   <= vy_r[14] ? 23'(-alu_st.res[22:0]) : alu_st.res[22:0];
                state_r <= S_NR;
              end
              S_NR: state_r <= S_DR;
              S_DR: begin
                if (spin_c[15]) begin
                  trate_r <= (alu_st.res[34:0] > 35'h080000000) ? 32'h80000000
                                                               : 32'(-alu_st.res[31:0]);
                end else begin
                  trate_r <= (alu_st.res[34:0] > 35'h07FFFFFFF) ? 32'h7FFFFFFF
                                                               : alu_st.res[31:0];
                end
                state_r <= S_NROT;
              end
              S_NROT: state_r <= S_DROT;
              S_DROT: begin
                rot_r   <= trate_r[31] ? -signed'({1'b0, alu_st.res[39:0]})
                                       :  signed'({1'b0, alu_st.res[39:0]});
                state_r <= S_WSET;
              end
              S_WMUL: state_r <= S_WDIV;
              S_WDIV: begin
                whl_r[widx_r] <= w_r[widx_r][42] ? 16'(43'd0 - wdiv_q) : 16'(wdiv_q);
                widx_r  <= widx_r + 2'd1;
                state_r <= (widx_r == 2'd3) ? S_DONE : S_WMUL;
              end
              S_MIXX: begin
                cvx_r   <= 23'(44'(cvx_r) + (mprod >>> 8));
                state_r <= S_MIXY;
              end
              S_MIXY: begin
                cvy_r   <= 23'(44'(cvy_r) + (mprod >>> 8));
                state_r <= S_MIXR;
              end
              S_MIXR: begin
                crate_r <= 32'(44'(crate_r) + (mprod >>> 8));
                state_r <= S_PXM;
              end
              S_PXM: state_r <= S_PXD;
              S_PXD: begin
                posx_r  <= posx_r + pdelta_x;
                state_r <= S_PYM;
              end
              S_PYM: state_r <= S_PYD;
              S_PYD: begin
                posy_r  <= posy_r + pdelta_y;
                state_r <= S_HM;
              end
              S_HM: state_r <= S_HD;
              S_HD: begin
                h_r <= hsum;
                if (hsum > HalfTurn || hsum < -HalfTurn) begin
                  state_r <= S_WRAP;
                end else begin
                  head_r  <= hsum[22:0];
                  state_r <= S_DONE;
                end
              end
              S_WRAP: begin
                head_r  <= hwrap[22:0];
                state_r <= S_DONE;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_alu_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    alu_st.done |-> wait_r)
    else $error("arithmetic unit finished with no operation outstanding");

  a_heading_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRAP && wait_r && alu_st.done) |=>
      (head_r <= 23'sd3141590 && head_r >= -23'sd3141590))
    else $error("heading left outside half turn after wrap");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r != S_IDLE))
    else $error("accepted item did not start processing");

endmodule
